// ----- rtl/shls_pkg.sv -----
package shls_pkg;

    localparam int LINE_KIND_W    = 4;
    localparam int FIELD_W        = 16;
    localparam int NAME_CMP_CHARS = 14;

    localparam logic [LINE_KIND_W-1:0] KIND_START      = 4'd0;
    localparam logic [LINE_KIND_W-1:0] KIND_VIA        = 4'd1;
    localparam logic [LINE_KIND_W-1:0] KIND_FROM       = 4'd2;
    localparam logic [LINE_KIND_W-1:0] KIND_TO         = 4'd3;
    localparam logic [LINE_KIND_W-1:0] KIND_CALL_ID    = 4'd4;
    localparam logic [LINE_KIND_W-1:0] KIND_CSEQ       = 4'd5;
    localparam logic [LINE_KIND_W-1:0] KIND_CONTACT    = 4'd6;
    localparam logic [LINE_KIND_W-1:0] KIND_CONTENT_LEN = 4'd7;
    localparam logic [LINE_KIND_W-1:0] KIND_HDR_END    = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_message;
    } t_in;

    typedef struct packed {
        logic [LINE_KIND_W-1:0] line_kind;
        logic [FIELD_W-1:0]     line_offset;
        logic [FIELD_W-1:0]     line_length;
        logic [FIELD_W-1:0]     token_length;
        logic                   is_response;
        logic                   start_valid;
        logic                   number_found;
        logic [FIELD_W-1:0]     number_offset;
        logic [FIELD_W-1:0]     number_length;
        logic                   too_long;
    } t_out;

endpackage

// ----- rtl/shls_name_match.sv -----
module shls_name_match #(
    parameter int NAME_CHARS_MAX = 14
) (
    input  logic [shls_pkg::NAME_CMP_CHARS-1:0][7:0]    i_chars,
    input  logic [$clog2(NAME_CHARS_MAX+1)-1:0]         i_count,
    output logic                                        o_hit,
    output logic [shls_pkg::LINE_KIND_W-1:0]            o_kind
);

    localparam int CNT_W = $clog2(NAME_CHARS_MAX + 1);
    localparam int W     = shls_pkg::NAME_CMP_CHARS * 8;

    logic [W-1:0] word;
    logic         one;

    // first name character in the top byte
    always_comb begin
        for (int i = 0; i < shls_pkg::NAME_CMP_CHARS; i++) begin
            word[8*(shls_pkg::NAME_CMP_CHARS-1-i) +: 8] = i_chars[i];
        end
    end

    assign one = (i_count == CNT_W'(1));

    always_comb begin
        o_hit  = 1'b1;
        o_kind = shls_pkg::KIND_START;
        if ((i_count == CNT_W'(3) && word[W-1 -: 24] == "via")
            || (one && word[W-1 -: 8] == "v")) begin
            o_kind = shls_pkg::KIND_VIA;
        end else if ((i_count == CNT_W'(4) && word[W-1 -: 32] == "from")
            || (one && word[W-1 -: 8] == "f")) begin
            o_kind = shls_pkg::KIND_FROM;
        end else if ((i_count == CNT_W'(2) && word[W-1 -: 16] == "to")
            || (one && word[W-1 -: 8] == "t")) begin
            o_kind = shls_pkg::KIND_TO;
        end else if ((i_count == CNT_W'(7) && word[W-1 -: 56] == "call-id")
            || (one && word[W-1 -: 8] == "i")) begin
            o_kind = shls_pkg::KIND_CALL_ID;
        end else if (i_count == CNT_W'(4) && word[W-1 -: 32] == "cseq") begin
            o_kind = shls_pkg::KIND_CSEQ;
        end else if ((i_count == CNT_W'(7) && word[W-1 -: 56] == "contact")
            || (one && word[W-1 -: 8] == "m")) begin
            o_kind = shls_pkg::KIND_CONTACT;
        end else if ((i_count == CNT_W'(14) && word[W-1 -: 112] == "content-length")
            || (one && word[W-1 -: 8] == "l")) begin
            o_kind = shls_pkg::KIND_CONTENT_LEN;
        end else begin
            o_hit = 1'b0;
        end
    end

endmodule

// ----- rtl/sip_header_line_scanner.sv -----
// SIP header line scanner
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one message byte per
// transfer, with last_of_message on the final byte of each message.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per
// recognized line: the start line, each known header line, and the end of
// the header (kind 8, giving the body offset). Other lines give nothing.
//
// Throughput is one byte per cycle unless the receiver stalls. A byte is
// captured in the input register, decoded, and its result (if any) sits in
// the output register: o_out_valid rises once the byte that ends the line
// has passed through the input register and its result is registered.
// When the receiver stalls, the result register holds and the input
// register fills; o_in_ready then drops until the result is taken.
// Reset clears all scan state: the next byte is offset zero of a new
// message, and the byte marked last_of_message returns the scanner to that
// same state.
module sip_header_line_scanner #(
    parameter int OFFSET_BITS    = 16,
    parameter int NAME_CHARS_MAX = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  shls_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output shls_pkg::t_out  o_out_data
);

    localparam int OB    = OFFSET_BITS;
    localparam int CNT_W = $clog2(NAME_CHARS_MAX + 1);
    localparam int IDX_W = $clog2(NAME_CHARS_MAX);
    localparam int CW    = (OB + 1 > 17) ? OB + 1 : 17;
    localparam logic [OB-1:0] OFF_MAX = '1;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_HDR   = 3'b010,
        PH_BODY  = 3'b100
    } t_phase;

    typedef enum logic [3:0] {
        NM_LEAD  = 4'b0001,
        NM_NAME  = 4'b0010,
        NM_TRAIL = 4'b0100,
        NM_COLON = 4'b1000
    } t_name_mode;

    typedef enum logic [2:0] {
        US_NONE  = 3'b001,
        US_SEEK  = 3'b010,
        US_FOUND = 3'b100
    } t_user_state;

    function automatic logic [16:0] clip16(input logic [OB:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w > CW'(17'h0FFFF)) begin
            return {1'b1, 16'hFFFF};
        end
        return {1'b0, w[15:0]};
    endfunction

    function automatic logic [7:0] resp_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return "S";
            3'd1:    return "I";
            3'd2:    return "P";
            3'd3:    return "/";
            3'd4:    return "2";
            3'd5:    return ".";
            3'd6:    return "0";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] uri_char(input logic [1:0] idx);
        case (idx)
            2'd0:    return "s";
            2'd1:    return "i";
            2'd2:    return "p";
            default: return ":";
        endcase
    endfunction

    // pipeline registers
    logic           r_in_valid;
    shls_pkg::t_in  r_in;
    logic           r_out_valid;
    shls_pkg::t_out r_out;

    // scan state
    logic [OB-1:0]    r_byte_offset, n_byte_offset;
    logic [OB-1:0]    r_line_begin, n_line_begin;
    t_phase           r_phase, n_phase;
    logic [NAME_CHARS_MAX-1:0][7:0] r_name_chars, name_view;
    logic [CNT_W-1:0] r_name_count, tk_name_count, n_name_count;
    t_name_mode       r_name_mode, tk_name_mode, n_name_mode;
    logic             r_name_broken, tk_name_broken, n_name_broken;
    logic [OB-1:0]    r_fte, tk_fte, n_fte;
    logic             r_tok_done, tk_tok_done, n_tok_done;
    logic [2:0]       r_resp_idx, tk_resp_idx, n_resp_idx;
    logic             r_resp_bad, tk_resp_bad, n_resp_bad;
    logic [2:0]       r_uri_step, tk_uri_step, n_uri_step;
    logic [OB-1:0]    r_user_start, tk_user_start, n_user_start;
    t_user_state      r_user_state, tk_user_state, n_user_state;
    logic [OB-1:0]    r_user_len, tk_user_len, n_user_len;
    logic             r_prev_cr, tk_prev_cr, n_prev_cr;
    logic             r_sat, n_sat;

    logic           advance, core_fire;
    logic [7:0]     c, lower_c;
    logic           last, is_lf, is_cr, is_ws;
    logic [OB-1:0]  pos, pos_inc_sat;
    logic           pos_at_max, sat_now;
    logic [OB:0]    pos_plus1, end_v, len_v, tok_full, tok_v, next_sat;
    logic           store_ok, do_store, name_wr;
    logic [2:0]     uri_nx;
    logic           match_hit;
    logic [shls_pkg::LINE_KIND_W-1:0] match_kind;
    logic [16:0]    lb_c, len_c, tok_c, nx_c, us_c, ul_c;
    logic           fin, res_valid;
    shls_pkg::t_out res;

    assign advance     = !r_out_valid || i_out_ready;
    assign core_fire   = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign c       = r_in.data_byte;
    assign last    = r_in.last_of_message;
    assign is_lf   = (c == 8'h0A);
    assign is_cr   = (c == 8'h0D);
    assign is_ws   = (c == " ") || (c >= 8'h09 && c <= 8'h0D);
    assign lower_c = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

    assign pos         = r_byte_offset;
    assign pos_at_max  = (pos == OFF_MAX);
    assign pos_inc_sat = pos_at_max ? OFF_MAX : pos + 1'b1;
    assign pos_plus1   = {1'b0, pos} + 1'b1;
    assign sat_now     = r_sat || pos_at_max;
    assign store_ok    = (r_name_count < CNT_W'(NAME_CHARS_MAX));

    // per-byte update of line state: held-back cr first, then this byte
    always_comb begin
        tk_name_count  = r_name_count;
        tk_name_mode   = r_name_mode;
        tk_name_broken = r_name_broken;
        tk_fte         = r_fte;
        tk_tok_done    = r_tok_done;
        tk_resp_idx    = r_resp_idx;
        tk_resp_bad    = r_resp_bad;
        tk_uri_step    = r_uri_step;
        tk_user_start  = r_user_start;
        tk_user_state  = r_user_state;
        tk_user_len    = r_user_len;
        tk_prev_cr     = r_prev_cr;
        do_store       = 1'b0;
        name_wr        = 1'b0;
        uri_nx         = '0;
        if (r_phase != PH_BODY && !is_lf) begin
            if (r_prev_cr) begin
                tk_prev_cr = 1'b0;
                if (r_phase == PH_START) begin
                    if (!r_tok_done) begin
                        tk_resp_bad = 1'b1;
                    end
                end else begin
                    if (r_name_mode == NM_NAME) begin
                        tk_name_mode = NM_TRAIL;
                    end
                    if (r_user_state == US_NONE) begin
                        tk_uri_step = '0;
                    end
                end
            end
            if (is_cr && !last) begin
                tk_prev_cr = 1'b1;
            end else if (r_phase == PH_START) begin
                if (!tk_tok_done) begin
                    if (c == " ") begin
                        tk_tok_done = 1'b1;
                        tk_fte      = pos;
                    end else if (tk_resp_idx != 3'd7 && c == resp_char(tk_resp_idx)) begin
                        tk_resp_idx = tk_resp_idx + 1'b1;
                    end else begin
                        tk_resp_bad = 1'b1;
                    end
                end
            end else begin
                if (tk_name_mode != NM_COLON) begin
                    if (c == ":") begin
                        tk_name_mode = NM_COLON;
                    end else if (tk_name_mode == NM_LEAD) begin
                        if (!is_ws) begin
                            do_store     = 1'b1;
                            tk_name_mode = NM_NAME;
                        end
                    end else if (tk_name_mode == NM_NAME) begin
                        if (is_ws) begin
                            tk_name_mode = NM_TRAIL;
                        end else begin
                            do_store = 1'b1;
                        end
                    end else if (!is_ws) begin
                        tk_name_broken = 1'b1;
                    end
                end
                if (do_store) begin
                    if (store_ok) begin
                        name_wr       = 1'b1;
                        tk_name_count = r_name_count + 1'b1;
                    end else begin
                        tk_name_broken = 1'b1;
                    end
                end
                if (tk_user_state == US_NONE) begin
                    if (c == uri_char(tk_uri_step[1:0])) begin
                        uri_nx = tk_uri_step + 1'b1;
                    end else if (c == "s") begin
                        uri_nx = 3'd1;
                    end else begin
                        uri_nx = 3'd0;
                    end
                    tk_uri_step = uri_nx;
                    if (uri_nx[2]) begin
                        tk_user_state = US_SEEK;
                        tk_user_start = pos_inc_sat;
                    end
                end else if (tk_user_state == US_SEEK && c == "@") begin
                    tk_user_state = US_FOUND;
                    tk_user_len   = (pos >= r_user_start) ? pos - r_user_start : '0;
                end
            end
        end
    end

    always_comb begin
        name_view = r_name_chars;
        if (name_wr) begin
            name_view[r_name_count[IDX_W-1:0]] = lower_c;
        end
    end

    shls_name_match #(
        .NAME_CHARS_MAX (NAME_CHARS_MAX)
    ) u_name_match (
        .i_chars (name_view[shls_pkg::NAME_CMP_CHARS-1:0]),
        .i_count (tk_name_count),
        .o_hit   (match_hit),
        .o_kind  (match_kind)
    );

    // line end positions
    always_comb begin
        if (is_lf) begin
            end_v = (r_prev_cr && pos > r_line_begin) ? {1'b0, pos - 1'b1} : {1'b0, pos};
        end else begin
            end_v = pos_plus1;
        end
    end

    assign len_v    = (end_v > {1'b0, r_line_begin}) ? end_v - {1'b0, r_line_begin} : '0;
    assign tok_full = tk_tok_done ? {1'b0, tk_fte - r_line_begin} : len_v;
    assign tok_v    = (tok_full > len_v) ? len_v : tok_full;
    assign next_sat = pos_plus1[OB] ? {1'b0, OFF_MAX} : pos_plus1;

    assign lb_c  = clip16({1'b0, r_line_begin});
    assign len_c = clip16(len_v);
    assign tok_c = clip16(tok_v);
    assign nx_c  = clip16(next_sat);
    assign us_c  = clip16({1'b0, tk_user_start});
    assign ul_c  = clip16({1'b0, tk_user_len});

    assign fin = (r_phase != PH_BODY) && (is_lf || last);

    // line result, then line and message restart
    always_comb begin
        n_byte_offset = pos_at_max ? pos : pos + 1'b1;
        n_sat         = sat_now;
        n_phase       = r_phase;
        n_line_begin  = r_line_begin;
        n_name_count  = tk_name_count;
        n_name_mode   = tk_name_mode;
        n_name_broken = tk_name_broken;
        n_fte         = tk_fte;
        n_tok_done    = tk_tok_done;
        n_resp_idx    = tk_resp_idx;
        n_resp_bad    = tk_resp_bad;
        n_uri_step    = tk_uri_step;
        n_user_start  = tk_user_start;
        n_user_state  = tk_user_state;
        n_user_len    = tk_user_len;
        n_prev_cr     = tk_prev_cr;
        res           = '0;
        res_valid     = 1'b0;
        if (fin) begin
            if (r_phase == PH_START) begin
                res_valid        = 1'b1;
                res.line_kind    = shls_pkg::KIND_START;
                res.line_offset  = lb_c[15:0];
                res.line_length  = len_c[15:0];
                res.token_length = tok_c[15:0];
                res.is_response  = !tk_resp_bad && tk_resp_idx == 3'd7;
                res.start_valid  = (len_v != '0) && (tok_v != '0);
                res.too_long     = sat_now || lb_c[16] || len_c[16] || tok_c[16];
                n_phase          = PH_HDR;
            end else if (len_v == '0) begin
                res_valid       = 1'b1;
                res.line_kind   = shls_pkg::KIND_HDR_END;
                res.line_offset = nx_c[15:0];
                res.too_long    = sat_now || pos_plus1[OB] || nx_c[16];
                n_phase         = PH_BODY;
            end else if (match_hit && tk_name_mode == NM_COLON && !tk_name_broken) begin
                res_valid       = 1'b1;
                res.line_kind   = match_kind;
                res.line_offset = lb_c[15:0];
                res.line_length = len_c[15:0];
                res.too_long    = sat_now || lb_c[16] || len_c[16];
                if (tk_user_state == US_FOUND) begin
                    res.number_found  = 1'b1;
                    res.number_offset = us_c[15:0];
                    res.number_length = ul_c[15:0];
                    res.too_long      = sat_now || lb_c[16] || len_c[16]
                                        || us_c[16] || ul_c[16];
                end
            end
        end
        if ((r_phase != PH_BODY && is_lf) || last) begin
            n_line_begin  = last ? '0 : pos_inc_sat;
            n_name_count  = '0;
            n_name_mode   = NM_LEAD;
            n_name_broken = 1'b0;
            n_fte         = '0;
            n_tok_done    = 1'b0;
            n_resp_idx    = '0;
            n_resp_bad    = 1'b0;
            n_uri_step    = '0;
            n_user_start  = '0;
            n_user_state  = US_NONE;
            n_user_len    = '0;
            n_prev_cr     = 1'b0;
        end
        if (last) begin
            n_byte_offset = '0;
            n_sat         = 1'b0;
            n_phase       = PH_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_byte_offset <= '0;
            r_line_begin  <= '0;
            r_phase       <= PH_START;
            r_name_count  <= '0;
            r_name_mode   <= NM_LEAD;
            r_name_broken <= 1'b0;
            r_fte         <= '0;
            r_tok_done    <= 1'b0;
            r_resp_idx    <= '0;
            r_resp_bad    <= 1'b0;
            r_uri_step    <= '0;
            r_user_start  <= '0;
            r_user_state  <= US_NONE;
            r_user_len    <= '0;
            r_prev_cr     <= 1'b0;
            r_sat         <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= core_fire && res_valid;
            end
            if (core_fire) begin
                r_byte_offset <= n_byte_offset;
                r_line_begin  <= n_line_begin;
                r_phase       <= n_phase;
                r_name_count  <= n_name_count;
                r_name_mode   <= n_name_mode;
                r_name_broken <= n_name_broken;
                r_fte         <= n_fte;
                r_tok_done    <= n_tok_done;
                r_resp_idx    <= n_resp_idx;
                r_resp_bad    <= n_resp_bad;
                r_uri_step    <= n_uri_step;
                r_user_start  <= n_user_start;
                r_user_state  <= n_user_state;
                r_user_len    <= n_user_len;
                r_prev_cr     <= n_prev_cr;
                r_sat         <= n_sat;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (core_fire) begin
            r_name_chars <= name_view;
        end
        if (core_fire && res_valid && advance) begin
            r_out <= res;
        end
    end

    // end of message brings back the initial scan state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_fire && r_in.last_of_message |=> r_byte_offset == '0 && r_phase == PH_START)
        else $error("scan state not restored after last byte");

    // body bytes never produce a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_fire && r_phase == PH_BODY |-> !res_valid)
        else $error("result produced inside message body");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.number_found
        |-> r_out.number_offset == '0 && r_out.number_length == '0)
        else $error("user part fields set without a user part");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start_valid
        |-> r_out.line_kind == shls_pkg::KIND_START && r_out.token_length != '0)
        else $error("start_valid on a line that is not a valid start line");

endmodule
